/* rtl/core/ccc_pkg.sv */
package ccc_pkg;

    // Block configuration.
    localparam int NUM_CLASSES       = 7;
    localparam int SAMPLES_PER_CLASS = 5;
    localparam int PERIOD_BITS       = 20;

    // Port widths.
    localparam int PERIOD_W = 20;
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 3;
    localparam int DIST_W   = PERIOD_W + 2;

    // Only the low PERIOD_BITS bits of a measured period take part.
    localparam int EFF_BITS = (PERIOD_BITS < PERIOD_W) ? PERIOD_BITS : PERIOD_W;
    localparam logic [PERIOD_W-1:0] PERIOD_MASK =
        PERIOD_W'((64'd1 << EFF_BITS) - 64'd1);

    // Internal widths.
    localparam int CLS_W  = $clog2(NUM_CLASSES + 1);
    localparam int LANE_W = $clog2(NUM_CLASSES);
    localparam int CNT_W  = $clog2(SAMPLES_PER_CLASS + 1);
    localparam int SUM_W  = PERIOD_W + $clog2(SAMPLES_PER_CLASS);

    // Division of a sum by SAMPLES_PER_CLASS as a multiply by a rounded-up
    // reciprocal and a shift. With the extra shift of log2 of the divisor
    // the truncated quotient is exact for every sum below 2**SUM_W.
    localparam int DIV_SH   = SUM_W + $clog2(SAMPLES_PER_CLASS);
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << DIV_SH) + longint'(SAMPLES_PER_CLASS) - 64'd1) / SAMPLES_PER_CLASS;

    typedef logic [DIST_W-1:0] dist_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_STORED   = 2'd1,
        KIND_CLASSIFY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] r;
        logic [PERIOD_W-1:0] g;
        logic [PERIOD_W-1:0] b;
    } triple_t;

    // Controls from the sequencer to the calibration accumulator.
    typedef struct packed {
        logic acc;
        logic div;
        logic clear;
    } calib_ctl_t;

    // Status and result of the merging stage.
    typedef struct packed {
        logic              done;
        logic [LANE_W-1:0] idx;
        dist_t             best_dist;
    } merge_stat_t;

    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   class_index;
        dist_t              distance;
        triple_t            avg;
    } res_t;

endpackage

/* rtl/core/ccc_lane.sv */
module ccc_lane (
    input  logic             clk,
    input  ccc_pkg::triple_t sample,
    input  ccc_pkg::triple_t reference,
    output ccc_pkg::dist_t   l1_dist
);

    logic [ccc_pkg::PERIOD_W-1:0] dr_reg;
    logic [ccc_pkg::PERIOD_W-1:0] dg_reg;
    logic [ccc_pkg::PERIOD_W-1:0] db_reg;
    ccc_pkg::dist_t               dist_reg;

    // First stage: absolute channel differences. Second stage: their sum.
    always_ff @(posedge clk)
    begin
        dr_reg <= (sample.r >= reference.r) ? (sample.r - reference.r)
                                            : (reference.r - sample.r);
        dg_reg <= (sample.g >= reference.g) ? (sample.g - reference.g)
                                            : (reference.g - sample.g);
        db_reg <= (sample.b >= reference.b) ? (sample.b - reference.b)
                                            : (reference.b - sample.b);
        dist_reg <= ccc_pkg::DIST_W'(dr_reg) + ccc_pkg::DIST_W'(dg_reg)
                  + ccc_pkg::DIST_W'(db_reg);
    end

    assign l1_dist = dist_reg;

endmodule

/* rtl/core/ccc_calib.sv */
module ccc_calib (
    input  logic                clk,
    input  logic                rst_n,
    input  ccc_pkg::calib_ctl_t ctl,
    input  ccc_pkg::triple_t    sample,
    output logic                last,
    output ccc_pkg::triple_t    avg
);

    logic [ccc_pkg::CNT_W-1:0]   count_reg;
    logic [ccc_pkg::SUM_W-1:0]   sum_r_reg;
    logic [ccc_pkg::SUM_W-1:0]   sum_g_reg;
    logic [ccc_pkg::SUM_W-1:0]   sum_b_reg;
    logic [ccc_pkg::PROD_W-1:0]  prod_r_reg;
    logic [ccc_pkg::PROD_W-1:0]  prod_g_reg;
    logic [ccc_pkg::PROD_W-1:0]  prod_b_reg;
    logic [ccc_pkg::RECIP_W-1:0] recip;

    assign recip = ccc_pkg::RECIP_W'(ccc_pkg::RECIP);
    assign last  = (count_reg == ccc_pkg::CNT_W'(ccc_pkg::SAMPLES_PER_CLASS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end
        else if (ctl.acc)
        begin
            count_reg <= last ? '0 : count_reg + 1'b1;
            sum_r_reg <= sum_r_reg + ccc_pkg::SUM_W'(sample.r);
            sum_g_reg <= sum_g_reg + ccc_pkg::SUM_W'(sample.g);
            sum_b_reg <= sum_b_reg + ccc_pkg::SUM_W'(sample.b);
        end
        else if (ctl.clear)
        begin
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end
    end

    // Reciprocal multiply, registered before the quotient is used.
    always_ff @(posedge clk)
    begin
        if (ctl.div)
        begin
            prod_r_reg <= ccc_pkg::PROD_W'(sum_r_reg) * ccc_pkg::PROD_W'(recip);
            prod_g_reg <= ccc_pkg::PROD_W'(sum_g_reg) * ccc_pkg::PROD_W'(recip);
            prod_b_reg <= ccc_pkg::PROD_W'(sum_b_reg) * ccc_pkg::PROD_W'(recip);
        end
    end

    assign avg.r = prod_r_reg[ccc_pkg::DIV_SH +: ccc_pkg::PERIOD_W];
    assign avg.g = prod_g_reg[ccc_pkg::DIV_SH +: ccc_pkg::PERIOD_W];
    assign avg.b = prod_b_reg[ccc_pkg::DIV_SH +: ccc_pkg::PERIOD_W];

endmodule

/* rtl/core/ccc_merge.sv */
module ccc_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ccc_pkg::dist_t       lane_dist [ccc_pkg::NUM_CLASSES],
    output ccc_pkg::merge_stat_t stat
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [ccc_pkg::LANE_W-1:0] k_reg;
    logic [ccc_pkg::LANE_W-1:0] best_idx_reg;
    ccc_pkg::dist_t             best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= ccc_pkg::LANE_W'(1);
            end
            else if (busy_reg)
            begin
                if (k_reg == ccc_pkg::LANE_W'(ccc_pkg::NUM_CLASSES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    // Strict less-than keeps the lowest lane index on a tie.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            best_reg     <= lane_dist[0];
            best_idx_reg <= '0;
        end
        else if (busy_reg && (lane_dist[k_reg] < best_reg))
        begin
            best_reg     <= lane_dist[k_reg];
            best_idx_reg <= k_reg;
        end
    end

    assign stat.done      = done_reg;
    assign stat.idx       = best_idx_reg;
    assign stat.best_dist = best_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("merge started while a walk is in progress");

    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("merge done without a walk");

    a_walk_skips_first: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (k_reg != '0))
        else $error("merge walk revisits the first lane");

endmodule

/* rtl/core/color_calibrate_and_classify.sv */
// A calibration sample gives one result, as does the fifth sample of a class (reference
// stored) and a classification. A new item is taken only once the last result has entered
// the output register; a classification waits for the merging stage, which loads lane 0
// and then walks the remaining lane distances one per cycle.
// Reset (rst_n, asynchronous) returns to calibrating class 0 with cleared accumulators;
// the reference table holds no value until calibration writes it.
module color_calibrate_and_classify (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [ccc_pkg::PERIOD_W-1:0]  red_period,
    input  logic [ccc_pkg::PERIOD_W-1:0]  green_period,
    input  logic [ccc_pkg::PERIOD_W-1:0]  blue_period,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ccc_pkg::KIND_W-1:0]    kind,
    output logic [ccc_pkg::IDX_W-1:0]     class_index,
    output logic [ccc_pkg::DIST_W-1:0]    distance,
    output logic [ccc_pkg::PERIOD_W-1:0]  avg_red,
    output logic [ccc_pkg::PERIOD_W-1:0]  avg_green,
    output logic [ccc_pkg::PERIOD_W-1:0]  avg_blue
);

    // One-hot sequencer. Calibration goes through CAL, and for the last
    // sample of a class also DIV and STORE. Classification goes through
    // the two lane stages, starts the merge and waits for it.
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CAL    = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_STORE  = 9'b000001000,
        S_LANE_A = 9'b000010000,
        S_LANE_B = 9'b000100000,
        S_MGO    = 9'b001000000,
        S_MERGE  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [ccc_pkg::CLS_W-1:0]   stage_reg;
    ccc_pkg::triple_t            sample_reg;
    ccc_pkg::triple_t            class_ref_reg [ccc_pkg::NUM_CLASSES];
    ccc_pkg::dist_t              lane_dist [ccc_pkg::NUM_CLASSES];
    ccc_pkg::res_t               res_reg;
    ccc_pkg::res_t               out_reg;
    logic                        result_valid_reg;
    ccc_pkg::calib_ctl_t         calib_ctl;
    ccc_pkg::triple_t            calib_avg;
    logic                        calib_last;
    ccc_pkg::merge_stat_t        merge_stat;
    logic                        accept;
    logic                        emit_ok;
    logic                        calibrated;

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    // The output register is free when empty or when its item leaves now.
    assign emit_ok      = !result_valid_reg || !result_stall;
    assign calibrated   = (stage_reg == ccc_pkg::CLS_W'(ccc_pkg::NUM_CLASSES));

    // Accepted periods are masked and held for the whole item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg.r <= red_period & ccc_pkg::PERIOD_MASK;
            sample_reg.g <= green_period & ccc_pkg::PERIOD_MASK;
            sample_reg.b <= blue_period & ccc_pkg::PERIOD_MASK;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = calibrated ? S_LANE_A : S_CAL;
            S_CAL:    state_next = calib_last ? S_DIV : S_EMIT;
            S_DIV:    state_next = S_STORE;
            S_STORE:  state_next = S_EMIT;
            S_LANE_A: state_next = S_LANE_B;
            S_LANE_B: state_next = S_MGO;
            S_MGO:    state_next = S_MERGE;
            S_MERGE:  if (merge_stat.done) state_next = S_EMIT;
            S_EMIT:   if (emit_ok) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_STORE)
            begin
                stage_reg <= stage_reg + 1'b1;
            end
        end
    end

    // Calibration accumulator and divider.
    assign calib_ctl.acc   = (state_reg == S_CAL);
    assign calib_ctl.div   = (state_reg == S_DIV);
    assign calib_ctl.clear = (state_reg == S_STORE);

    ccc_calib u_calib (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (calib_ctl),
        .sample (sample_reg),
        .last   (calib_last),
        .avg    (calib_avg)
    );

    // Reference table: one register per class, each read by its own lane.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ccc_pkg::NUM_CLASSES; i++)
        begin
            if ((state_reg == S_STORE) && (stage_reg == ccc_pkg::CLS_W'(i)))
            begin
                class_ref_reg[i] <= calib_avg;
            end
        end
    end

    // Distance lanes, one per class, all working on the same sample.
    for (genvar l = 0; l < ccc_pkg::NUM_CLASSES; l++)
    begin : g_lane
        ccc_lane u_lane (
            .clk       (clk),
            .sample    (sample_reg),
            .reference (class_ref_reg[l]),
            .l1_dist   (lane_dist[l])
        );
    end

    // The merging stage picks the nearest class from the lane distances.
    ccc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_MGO),
        .lane_dist (lane_dist),
        .stat      (merge_stat)
    );

    // Pending result of the current item.
    always_ff @(posedge clk)
    begin
        priority if ((state_reg == S_CAL) && !calib_last)
        begin
            res_reg.kind        <= ccc_pkg::KIND_SAMPLE;
            res_reg.class_index <= ccc_pkg::IDX_W'(stage_reg);
            res_reg.distance    <= '0;
            res_reg.avg         <= '0;
        end
        else if (state_reg == S_STORE)
        begin
            res_reg.kind        <= ccc_pkg::KIND_STORED;
            res_reg.class_index <= ccc_pkg::IDX_W'(stage_reg);
            res_reg.distance    <= '0;
            res_reg.avg         <= calib_avg;
        end
        else if ((state_reg == S_MERGE) && merge_stat.done)
        begin
            res_reg.kind        <= ccc_pkg::KIND_CLASSIFY;
            res_reg.class_index <= ccc_pkg::IDX_W'(merge_stat.idx);
            res_reg.distance    <= merge_stat.best_dist;
            res_reg.avg         <= '0;
        end
        else
        begin
            res_reg <= res_reg;
        end
    end

    // Output register: separates the result channel from the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_EMIT) && emit_ok)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_EMIT) && emit_ok)
        begin
            out_reg <= res_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = out_reg.kind;
    assign class_index  = out_reg.class_index;
    assign distance     = out_reg.distance;
    assign avg_red      = out_reg.avg.r;
    assign avg_green    = out_reg.avg.g;
    assign avg_blue     = out_reg.avg.b;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    a_stage_steps_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |=> (stage_reg == ccc_pkg::CLS_W'($past(stage_reg) + 1'b1)))
        else $error("class counter did not advance on store");

    a_classify_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LANE_A) |-> calibrated)
        else $error("classification before calibration finished");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result appeared outside the emit step");

endmodule

/* bench/tb_color_calibrate_and_classify.sv */
`timescale 1ns / 1ps

module tb_color_calibrate_and_classify;
    import ccc_pkg::*;

    // The run is stopped if it has not drained by this many clock cycles.
    localparam int LIMIT_CYCLES = 1000000;
    // Number of random classification items after the directed part.
    localparam int RANDOM_ITEMS = 1800;
    // Receiver cycle at which the first long hold-off starts.
    localparam int FIRST_HOLD_AT = 1200;
    // Every this many random items, the sender waits for the block to drain.
    localparam int DRAIN_EVERY = 450;

    localparam logic [PERIOD_W-1:0] PERIOD_TOP = '1;
    localparam logic [DIST_W-1:0]   DIST_TOP   = '1;

    // One pending item for the driver. When drain_first is set, the driver holds
    // the item back until every expected result has come out of the block.
    typedef struct {
        triple_t color;
        bit      drain_first;
    } sample_item_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [PERIOD_W-1:0] red_period   = '0;
    logic [PERIOD_W-1:0] green_period = '0;
    logic [PERIOD_W-1:0] blue_period  = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    class_index;
    logic [DIST_W-1:0]   distance;
    logic [PERIOD_W-1:0] avg_red;
    logic [PERIOD_W-1:0] avg_green;
    logic [PERIOD_W-1:0] avg_blue;

    // Items waiting to be offered, and results predicted for accepted items.
    sample_item_t pending_samples[$];
    res_t         expected_results[$];
    // Calibration samples, kept so that random items can land near the references.
    triple_t      calib_samples[$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Predictor state: the class being calibrated, the samples absorbed for it,
    // the running channel sums and the stored reference of every class.
    int unsigned class_stage   = 0;
    int unsigned samples_taken = 0;
    logic [31:0] red_acc       = '0;
    logic [31:0] green_acc     = '0;
    logic [31:0] blue_acc      = '0;
    triple_t     class_refs[NUM_CLASSES];

    // Driver and receiver pacing state.
    triple_t offered_color;
    bit      offer_open = 1'b0;
    int      send_gap   = 0;
    int      send_calm  = 0;
    int      hold_left  = 0;
    int      recv_calm  = 0;
    int      recv_cycles = 0;

    color_calibrate_and_classify dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .red_period   (red_period),
        .green_period (green_period),
        .blue_period  (blue_period),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .class_index  (class_index),
        .distance     (distance),
        .avg_red      (avg_red),
        .avg_green    (avg_green),
        .avg_blue     (avg_blue)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic triple_t rgb(logic [PERIOD_W-1:0] r, logic [PERIOD_W-1:0] g,
                                    logic [PERIOD_W-1:0] b);
        triple_t c;
        c.r = r;
        c.g = g;
        c.b = b;
        return c;
    endfunction

    function automatic logic [31:0] abs_gap(logic [PERIOD_W-1:0] a, logic [PERIOD_W-1:0] b);
        return (a >= b) ? 32'(a - b) : 32'(b - a);
    endfunction

    // Works out the result of one accepted item and advances the predictor state.
    // While calibrating, the item is added to the sums of the current class; the
    // last sample of a class stores the truncated averages and clears the sums.
    // Once every class is stored, the item is matched to the reference with the
    // smallest summed absolute difference, the lowest index winning a tie.
    function automatic res_t calibrate_or_classify(triple_t raw);
        triple_t     c;
        res_t        r;
        logic [31:0] d;
        logic [31:0] best;
        int          best_idx;
        c.r = raw.r & PERIOD_MASK;
        c.g = raw.g & PERIOD_MASK;
        c.b = raw.b & PERIOD_MASK;
        r = '0;
        if (class_stage < NUM_CLASSES)
        begin
            red_acc   += c.r;
            green_acc += c.g;
            blue_acc  += c.b;
            samples_taken++;
            r.kind = KIND_SAMPLE;
            r.class_index = IDX_W'(class_stage);
            if (samples_taken >= SAMPLES_PER_CLASS)
            begin
                class_refs[class_stage].r = PERIOD_W'(red_acc / SAMPLES_PER_CLASS);
                class_refs[class_stage].g = PERIOD_W'(green_acc / SAMPLES_PER_CLASS);
                class_refs[class_stage].b = PERIOD_W'(blue_acc / SAMPLES_PER_CLASS);
                r.kind = KIND_STORED;
                r.avg = class_refs[class_stage];
                red_acc = '0;
                green_acc = '0;
                blue_acc = '0;
                samples_taken = 0;
                class_stage++;
            end
        end
        else
        begin
            best = '0;
            best_idx = 0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                d = abs_gap(c.r, class_refs[i].r) + abs_gap(c.g, class_refs[i].g)
                  + abs_gap(c.b, class_refs[i].b);
                if (i == 0 || d < best)
                begin
                    best = d;
                    best_idx = i;
                end
            end
            r.kind = KIND_CLASSIFY;
            r.class_index = IDX_W'(best_idx);
            r.distance = (best > DIST_TOP) ? DIST_TOP : DIST_W'(best);
        end
        return r;
    endfunction

    // Gap lengths for both sides: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Moves a channel value by a small random amount, kept inside the field range.
    function automatic logic [PERIOD_W-1:0] nudge(logic [PERIOD_W-1:0] v, int spread);
        int     offset;
        longint moved;
        offset = int'($urandom_range(0, 2 * spread)) - spread;
        moved = longint'(v) + offset;
        if (moved < 0)
            moved = 0;
        if (moved > longint'(PERIOD_TOP))
            moved = longint'(PERIOD_TOP);
        return PERIOD_W'(moved);
    endfunction

    // A channel value at one of the range ends or anywhere in between.
    function automatic logic [PERIOD_W-1:0] pick_level();
        case ($urandom_range(0, 2))
            0: return '0;
            1: return PERIOD_TOP;
            default: return PERIOD_W'($urandom());
        endcase
    endfunction

    function automatic triple_t random_color();
        return rgb(PERIOD_W'($urandom()), PERIOD_W'($urandom()), PERIOD_W'($urandom()));
    endfunction

    // A color from small channel values.
    function automatic triple_t small_rgb(int r, int g, int b);
        return rgb(PERIOD_W'(r), PERIOD_W'(g), PERIOD_W'(b));
    endfunction

    task automatic queue_sample(triple_t c, bit drain_first);
        sample_item_t it;
        it.color = c;
        it.drain_first = drain_first;
        pending_samples.push_back(it);
    endtask

    task automatic queue_calibration(triple_t c);
        calib_samples.push_back(c);
        queue_sample(c, 1'b0);
    endtask

    task automatic report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
        if (mismatch_count < 40)
            $display("%0t ns  %s: got %0d, expected %0d", $time, what, seen, wanted);
        mismatch_count++;
    endtask

    // Driver. The offered item stays on the ports until the block accepts it.
    // An accepted item is run through the predictor at once, so the store of
    // expected results always matches what the block has taken in. The next
    // item follows after a random gap; stretches of calm send back to back.
    always @(posedge clk or negedge rst_n)
    begin
        sample_item_t next_item;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                expected_results.push_back(calibrate_or_classify(offered_color));
                offer_open = 1'b0;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0 &&
                         !(pending_samples[0].drain_first && expected_results.size() != 0))
                begin
                    next_item = pending_samples.pop_front();
                    offered_color = next_item.color;
                    offer_open = 1'b1;
                    red_period <= next_item.color.r;
                    green_period <= next_item.color.g;
                    blue_period <= next_item.color.b;
                    sample_valid <= 1'b1;
                    send_gap = (send_calm > 0) ? 0 : pick_gap();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 299) == 0)
                send_calm = $urandom_range(50, 300);
        end
    end

    // Receiver. It stalls for random stretches and, now and then, holds off long
    // enough that the block fills up and stalls its input while the driver keeps
    // offering items. The first long hold-off starts when the receiver's cycle
    // counter reaches FIRST_HOLD_AT, well after calibration has finished.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            recv_cycles++;
            if (recv_cycles == FIRST_HOLD_AT)
            begin
                hold_left = $urandom_range(300, 500);
            end
            else if (hold_left == 0)
            begin
                if ($urandom_range(0, 3999) == 0)
                    hold_left = $urandom_range(300, 500);
                else if (recv_calm == 0 && $urandom_range(0, 2) == 0)
                    hold_left = pick_gap();
            end
            if (recv_calm > 0)
                recv_calm--;
            else if ($urandom_range(0, 299) == 0)
                recv_calm = $urandom_range(50, 300);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Monitor. Every accepted result is compared field by field with the oldest
    // prediction. Fields that must be zero for a kind are compared as well.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no item waiting, kind", kind, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (class_index !== want.class_index)
                    report_mismatch("class_index", class_index, want.class_index);
                if (distance !== want.distance)
                    report_mismatch("distance", distance, want.distance);
                if (avg_red !== want.avg.r)
                    report_mismatch("avg_red", avg_red, want.avg.r);
                if (avg_green !== want.avg.g)
                    report_mismatch("avg_green", avg_green, want.avg.g);
                if (avg_blue !== want.avg.b)
                    report_mismatch("avg_blue", avg_blue, want.avg.b);
            end
        end
    end

    // Watchdog: a block that hangs or loses results ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        triple_t c;
        int      roll;
        logic [PERIOD_W-1:0] alt_a;
        logic [PERIOD_W-1:0] alt_b;
        alt_a = {(PERIOD_W / 2){2'b10}};
        alt_b = ~alt_a;

        // Calibration. The first class sees only zeros and the second only the
        // largest period, so the references sit at both corners of the range.
        for (int i = 0; i < SAMPLES_PER_CLASS; i++)
            queue_calibration(rgb('0, '0, '0));
        for (int i = 0; i < SAMPLES_PER_CLASS; i++)
            queue_calibration(rgb(PERIOD_TOP, PERIOD_TOP, PERIOD_TOP));
        // The third class is random; the fifth class repeats its samples below,
        // which gives two equal references and therefore exact distance ties.
        for (int i = 0; i < SAMPLES_PER_CLASS; i++)
            queue_calibration(random_color());
        // Small sums that do not divide evenly check the truncated average.
        queue_calibration(small_rgb(1, 0, 4));
        queue_calibration(small_rgb(2, 0, 4));
        queue_calibration(small_rgb(3, 0, 4));
        queue_calibration(small_rgb(4, 0, 4));
        queue_calibration(small_rgb(4, 1, 3));
        for (int i = 0; i < SAMPLES_PER_CLASS; i++)
            queue_calibration(calib_samples[2 * SAMPLES_PER_CLASS + i]);
        // Alternating bit patterns, then a fully random class.
        queue_calibration(rgb(alt_a, alt_b, PERIOD_TOP));
        queue_calibration(rgb(alt_b, alt_a, '0));
        queue_calibration(rgb(alt_a, alt_a, alt_b));
        queue_calibration(rgb(alt_b, alt_b, alt_a));
        queue_calibration(rgb(alt_a, PERIOD_TOP, '0));
        for (int i = 0; i < SAMPLES_PER_CLASS; i++)
            queue_calibration(random_color());

        // Directed classification. The first one waits until calibration has
        // fully drained. Corners, single full channels, points on and near the small
        // reference, and a repeated sample that lies equally far from the two
        // equal references, where the lower class index has to win.
        queue_sample(rgb('0, '0, '0), 1'b1);
        queue_sample(rgb(PERIOD_TOP, PERIOD_TOP, PERIOD_TOP), 1'b0);
        queue_sample(rgb(PERIOD_TOP, '0, '0), 1'b0);
        queue_sample(rgb('0, PERIOD_TOP, '0), 1'b0);
        queue_sample(rgb('0, '0, PERIOD_TOP), 1'b0);
        queue_sample(small_rgb(2, 0, 3), 1'b0);
        queue_sample(small_rgb(1, 0, 3), 1'b0);
        queue_sample(small_rgb(3, 0, 1), 1'b0);
        queue_sample(calib_samples[2 * SAMPLES_PER_CLASS], 1'b0);
        queue_sample(calib_samples[2 * SAMPLES_PER_CLASS + 3], 1'b0);
        queue_sample(rgb(alt_a, alt_b, alt_a), 1'b0);
        queue_sample(rgb(alt_b, alt_a, alt_b), 1'b0);

        // Random classification. Two in five items fall near or onto calibration
        // samples so that the winning class changes often and ties occur; the
        // rest cover the whole range, the corners and very small periods.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                c = random_color();
            end
            else if (roll < 70)
            begin
                c = calib_samples[$urandom_range(0, calib_samples.size() - 1)];
                c = rgb(nudge(c.r, 300), nudge(c.g, 300), nudge(c.b, 300));
            end
            else if (roll < 80)
            begin
                c = calib_samples[$urandom_range(0, calib_samples.size() - 1)];
            end
            else if (roll < 90)
            begin
                c = rgb(pick_level(), pick_level(), pick_level());
            end
            else
            begin
                c = rgb(PERIOD_W'($urandom_range(0, 15)), PERIOD_W'($urandom_range(0, 15)),
                        PERIOD_W'($urandom_range(0, 15)));
            end
            queue_sample(c, (n % DRAIN_EVERY) == DRAIN_EVERY - 1);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item has been taken and every result has come out,
        // then give the block a short tail in which any extra result is caught.
        while (pending_samples.size() != 0 || offer_open || expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ccc_pkg.sv
rtl/core/ccc_lane.sv
rtl/core/ccc_calib.sv
rtl/core/ccc_merge.sv
rtl/core/color_calibrate_and_classify.sv
bench/tb_color_calibrate_and_classify.sv
